### src/bhpq_pkg.sv
// Shared types and codes for the binary heap priority queue.
package bhpq_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Register indexes on the configuration port (word address bit).
  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [10:0] CAPACITY_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic [31:0] top_value;
    logic        top_valid;
    logic [10:0] entry_total;
  } out_item_t;

  typedef struct packed {
    logic        max_heap_mode;
    logic [10:0] capacity_limit;
  } cfg_t;

endpackage

### src/bhpq_mem.sv
// Heap storage: one write port, two read ports, registered read data.
module bhpq_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

### src/bhpq_cfg.sv
// APB-style register file for heap mode and capacity limit.
module bhpq_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bhpq_pkg::cfg_t      cfg_o
);

  logic        mode_q;
  logic [10:0] cap_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cap_q  <= bhpq_pkg::CAPACITY_RESET;
    end else if (wr_en) begin
      if (paddr[2] == bhpq_pkg::REG_MODE) begin
        mode_q <= pwdata[0];
      end else begin
        cap_q <= pwdata[10:0];
      end
    end
  end

  assign prdata = (paddr[2] == bhpq_pkg::REG_CAPACITY) ? {21'b0, cap_q} : {31'b0, mode_q};

  assign cfg_o.max_heap_mode  = mode_q;
  assign cfg_o.capacity_limit = cap_q;

endmodule

### src/binary_heap_priority_queue.sv
// Binary heap priority queue: sequencer, output register and storage.
//
// Each input item is a push, a pop or a replace-top; each produces exactly
// one result item with the status, the popped value, the new root and the
// entry count. The heap lives in a synchronous memory of DEPTH entries with
// one write and two read ports; a sift walks one heap level per clock cycle
// (read the parent, or both children, and write one entry back), then the
// moving value is written to its final slot; a pop that must fetch the last
// entry reads it before the sift. Full, empty and unknown operations go
// straight to the result. The root is mirrored in a register so the top is
// known without a memory read. One item is in work at a time; a finished
// result waits in the output register while the next item is taken in. The
// mode register picks min- or max-heap; the user must write it and the
// capacity limit only while the block is idle; the block does not enforce it.
module binary_heap_priority_queue #(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bhpq_pkg::in_item_t    in_data_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bhpq_pkg::out_item_t   out_data_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = $clog2(DEPTH);      // memory address
  localparam int CW = $clog2(DEPTH + 1);  // entry count, holds DEPTH itself
  localparam int KW = AW + 2;             // child index, may run past DEPTH
  localparam int LW = (CW > 11) ? CW : 11;
  localparam int EW = ELEMENT_WIDTH;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LAST_RD = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_DN_CMP  = 7'b0001000,
    S_WR_END  = 7'b0010000,
    S_DONE    = 7'b0100000,
    S_SPARE   = 7'b1000000
  } state_e;

  // True when a must sit strictly nearer the root than b.
  function automatic logic ranks_above(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                       input logic max_mode);
    ranks_above = max_mode ? (a > b) : (a < b);
  endfunction

  bhpq_pkg::cfg_t cfg;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [EW-1:0] moving_q, moving_d;
  logic [EW-1:0] top_q;
  logic [1:0]    status_q, status_d;
  logic [EW-1:0] popped_q, popped_d;
  logic          out_valid_q;
  bhpq_pkg::out_item_t out_q;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  logic [EW-1:0] ra_data, rb_data;

  // datapath helpers
  logic [EW-1:0] val_in;
  logic [LW-1:0] limit;
  logic [CW-1:0] last_idx;
  logic [AW-1:0] push_par;
  logic [AW-1:0] par;
  logic [AW-1:0] par_par;
  logic [KW-1:0] lk, rk, nk, nk_r;
  logic          right_ok, pick_right;
  logic [EW-1:0] pick;
  logic [AW-1:0] sel;
  logic          out_free;

  bhpq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bhpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  assign val_in   = EW'(in_data_i.value_in);
  // Effective capacity is the smaller of the register and the store depth.
  assign limit    = (LW'(cfg.capacity_limit) < LW'(DEPTH)) ? LW'(cfg.capacity_limit)
                                                            : LW'(DEPTH);
  assign last_idx = count_q - CW'(1);
  assign push_par = (count_q[AW-1:0] - AW'(1)) >> 1;
  assign par      = (pos_q - AW'(1)) >> 1;
  assign par_par  = (par - AW'(1)) >> 1;

  // Sift-down child selection: right child only when it ranks strictly above.
  assign lk         = KW'({pos_q, 1'b1});
  assign rk         = lk + KW'(1);
  assign right_ok   = rk < KW'(count_q);
  assign pick_right = right_ok && ranks_above(rb_data, ra_data, cfg.max_heap_mode);
  assign pick       = pick_right ? rb_data : ra_data;
  assign sel        = pick_right ? rk[AW-1:0] : lk[AW-1:0];
  assign nk         = KW'({sel, 1'b1});
  assign nk_r       = nk + KW'(1);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    moving_d  = moving_q;
    status_d  = status_q;
    popped_d  = popped_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = moving_q;
    ra_addr   = '0;
    rb_addr   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = bhpq_pkg::ST_OK;
          popped_d = '0;
          state_d  = S_DONE;
          case (in_data_i.operation)
            bhpq_pkg::OP_PUSH: begin
              if (LW'(count_q) >= limit) begin
                status_d = bhpq_pkg::ST_FULL;
              end else begin
                count_d  = count_q + CW'(1);
                pos_d    = count_q[AW-1:0];
                moving_d = val_in;
                if (count_q == '0) begin
                  state_d = S_WR_END;
                end else begin
                  ra_addr = push_par;
                  state_d = S_UP_CMP;
                end
              end
            end
            bhpq_pkg::OP_POP: begin
              if (count_q == '0) begin
                status_d = bhpq_pkg::ST_EMPTY;
              end else begin
                popped_d = top_q;
                count_d  = last_idx;
                if (count_q != CW'(1)) begin
                  ra_addr = last_idx[AW-1:0];
                  state_d = S_LAST_RD;
                end
              end
            end
            bhpq_pkg::OP_REPLACE: begin
              if (count_q == '0) begin
                status_d = bhpq_pkg::ST_EMPTY;
              end else begin
                moving_d = val_in;
                pos_d    = '0;
                if (count_q > CW'(1)) begin
                  ra_addr = AW'(1);
                  rb_addr = AW'(2);
                  state_d = S_DN_CMP;
                end else begin
                  state_d = S_WR_END;
                end
              end
            end
            default: begin
              status_d = bhpq_pkg::ST_OK;
            end
          endcase
        end
      end
      S_LAST_RD: begin
        // Last entry arrives; sift it down from the root.
        moving_d = ra_data;
        pos_d    = '0;
        if (count_q > CW'(1)) begin
          ra_addr = AW'(1);
          rb_addr = AW'(2);
          state_d = S_DN_CMP;
        end else begin
          state_d = S_WR_END;
        end
      end
      S_UP_CMP: begin
        if (ranks_above(ra_data, moving_q, cfg.max_heap_mode)) begin
          state_d = S_WR_END;
        end else begin
          // Move the parent down one level and climb.
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = ra_data;
          pos_d     = par;
          if (par == '0) begin
            state_d = S_WR_END;
          end else begin
            ra_addr = par_par;
          end
        end
      end
      S_DN_CMP: begin
        if (ranks_above(moving_q, pick, cfg.max_heap_mode)) begin
          state_d = S_WR_END;
        end else begin
          // Pull the chosen child up one level and descend.
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = pick;
          pos_d     = sel;
          if (nk < KW'(count_q)) begin
            ra_addr = nk[AW-1:0];
            rb_addr = nk_r[AW-1:0];
          end else begin
            state_d = S_WR_END;
          end
        end
      end
      S_WR_END: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; mirror every write to the root into top_q.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    moving_q <= moving_d;
    status_q <= status_d;
    popped_q <= popped_d;
    if (mem_we && mem_waddr == '0) begin
      top_q <= mem_wdata;
    end
    if (state_q == S_DONE && out_free) begin
      out_q.status       <= status_q;
      out_q.popped_value <= 32'(popped_q);
      out_q.top_value    <= (count_q != '0) ? 32'(top_q) : 32'd0;
      out_q.top_valid    <= (count_q != '0);
      out_q.entry_total  <= 11'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
